>>> rtl/tdtc_pkg.sv
package tdtc_pkg;

    // Field widths
    localparam int ACQ_W    = 64;
    localparam int FID_W    = 17;
    localparam int SEC_W    = 32;
    localparam int NSEC_W   = 30;
    localparam int WRAP_W   = 18;
    localparam int LGAP_W   = 40;
    localparam int TIME_W   = 64;
    localparam int FGAP_W   = 32;
    localparam int QRND_W   = 43;
    localparam int WEIGH_W  = 75;

    // Stream and register port widths
    localparam int S_DATA_W = 144;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 8;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 64;

    // Arithmetic constants
    localparam int NS_PER_FID_W = 22;
    localparam int PS_PER_NS_W  = 10;
    localparam int NS_PER_S_W   = 30;
    localparam logic [NS_PER_FID_W-1:0] NS_PER_FIDUCIAL = 22'd2777777;
    localparam logic [PS_PER_NS_W-1:0]  PS_PER_NS       = 10'd1000;
    localparam logic [NS_PER_S_W-1:0]   NS_PER_S        = 30'd1000000000;
    localparam logic [3:0]              TOL_NUM         = 4'd13;
    localparam logic [10:0]             TOL_DEN         = 11'd2000;

    // Long division by a constant, 16 bits per digit: estimate each digit by
    // reciprocal multiplication, then fix it by compare and subtract
    localparam int DIG_W   = 16;
    localparam int DIGITS  = TIME_W / DIG_W;
    localparam int RCP_W   = 17;
    localparam int ACQ_T_W = PS_PER_NS_W + DIG_W;
    localparam int CLK_T_W = NS_PER_FID_W + DIG_W;
    // floor(2^26 / 1000) and floor(2^38 / 2777777); the partial dividend stays below 2^26
    // and 2^38, so an estimate is at most one below the true digit
    localparam logic [RCP_W-1:0] ACQ_RCP = 17'd67108;
    localparam logic [RCP_W-1:0] CLK_RCP = 17'd98956;

    localparam int DIV_STEPS = 2 * DIGITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Register reset values
    localparam logic [WRAP_W-1:0] WRAP_RESET = 18'd131040;
    localparam logic [LGAP_W-1:0] LGAP_RESET = 40'd300000000000;

    // Register map (byte address bit 3 selects the register)
    localparam logic REG_FID_WRAP = 1'b0;
    localparam logic REG_LONG_GAP = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIFF,
        ST_DIV,
        ST_ROUND,
        ST_SCALE,
        ST_SELECT,
        ST_WEIGH,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        KIND_CHECK,
        KIND_RESET,
        KIND_SKIP
    } kind_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_DIFF,
        OP_DIV_EST,
        OP_DIV_FIX,
        OP_ROUND,
        OP_SCALE,
        OP_SELECT,
        OP_WEIGH,
        OP_COMMIT,
        OP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_ctrl_t;

    typedef struct packed {
        logic mark;
        logic post;
    } dp_stat_t;

    typedef struct packed {
        logic [NSEC_W-1:0] clock_nanoseconds;
        logic [SEC_W-1:0]  clock_seconds;
        logic [FID_W-1:0]  fiducial;
        logic [ACQ_W-1:0]  acq_time_ps;
    } event_t;

endpackage

>>> rtl/trigger_drop_timestamp_checker.sv
// Channel   | Dir | Signals                            | Content
// ----------+-----+------------------------------------+---------------------------------
// s_*       | in  | s_tvalid s_tready s_tdata s_tuser  | one event or reset command
// m_*       | out | m_tvalid m_tready m_tdata          | mark and readout-clear flags
// APB       | in  | psel penable pwrite paddr pwdata   | fiducial_wrap at 0x0,
//           |     | prdata pready                      | long_gap_ns at 0x8
//
// An event to check goes from accept through the prep and diff steps to the two
// 64-bit divisions (by 1000 and by the fiducial period), which run side by side, 16 bits
// per digit, each digit an estimate step and a fix step, then through the round, scale,
// select, weigh and finish steps. A reset command or a damaged event goes straight to finish.
// Reset clears the flags, the stored timestamps and the registers to their defaults.
// A stalled m_tready holds the result; the next event is taken meanwhile and
// waits in the finish step until the output register frees up.
module trigger_drop_timestamp_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata: acq_time_ps[63:0], fiducial[80:64], clock_seconds[112:81],
    //          clock_nanoseconds[142:113], zero[143]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tdtc_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: cmd[0], input_damaged[1]
    input  logic [tdtc_pkg::S_USER_W-1:0]   s_tuser,
    // m_tdata: mark_out_of_order[0], post_clear_readout[1], zero[7:2]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tdtc_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tdtc_pkg::APB_AW-1:0]     paddr,
    input  logic [tdtc_pkg::APB_DW-1:0]     pwdata,
    output logic [tdtc_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import tdtc_pkg::*;

    logic [WRAP_W-1:0] wrap_reg, wrap_next;
    logic [LGAP_W-1:0] lgap_reg, lgap_next;
    logic              cfg_wr;
    dp_ctrl_t          dp_ctrl;
    dp_stat_t          dp_stat;
    event_t            ev;
    logic              m_mark;
    logic              m_post;

    // Configuration registers: write on the access beat, read at any time
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        wrap_next = wrap_reg;
        lgap_next = lgap_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3])
                REG_FID_WRAP: wrap_next = pwdata[WRAP_W-1:0];
                REG_LONG_GAP: lgap_next = pwdata[LGAP_W-1:0];
                default:      wrap_next = wrap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg <= WRAP_RESET;
            lgap_reg <= LGAP_RESET;
        end
        else
        begin
            wrap_reg <= wrap_next;
            lgap_reg <= lgap_next;
        end
    end

    assign prdata = (paddr[3] == REG_LONG_GAP) ? APB_DW'(lgap_reg) : APB_DW'(wrap_reg);

    // Unpack the event beat
    assign ev = event_t'(s_tdata[S_DATA_W-2:0]);

    tdtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_cmd     (s_tuser[0]),
        .s_damaged (s_tuser[1]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_mark    (m_mark),
        .m_post    (m_post),
        .dp_ctrl   (dp_ctrl),
        .dp_stat   (dp_stat)
    );

    tdtc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_ctrl       (dp_ctrl),
        .dp_stat       (dp_stat),
        .ev            (ev),
        .fiducial_wrap (wrap_reg),
        .long_gap_ns   (lgap_reg)
    );

    // Pack the result beat
    assign m_tdata = {(M_DATA_W-2)'(0), m_post, m_mark};

endmodule

>>> rtl/tdtc_ctrl.sv
module tdtc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_cmd,
    input  logic              s_damaged,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_mark,
    output logic              m_post,
    output tdtc_pkg::dp_ctrl_t dp_ctrl,
    input  tdtc_pkg::dp_stat_t dp_stat
);
    import tdtc_pkg::*;

    state_t               state_reg, state_next;
    kind_t                kind_reg, kind_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_mark_reg, out_mark_next;
    logic                 out_post_reg, out_post_next;
    logic                 out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_CHECK;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_mark_reg <= out_mark_next;
        out_post_reg <= out_post_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_mark_next  = out_mark_reg;
        out_post_next  = out_post_reg;
        dp_ctrl.op     = OP_NONE;
        s_tready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    dp_ctrl.op = OP_LOAD;
                    if (s_cmd)
                    begin
                        kind_next  = KIND_RESET;
                        state_next = ST_FINISH;
                    end
                    else if (s_damaged)
                    begin
                        kind_next  = KIND_SKIP;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        kind_next  = KIND_CHECK;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                dp_ctrl.op = OP_PREP;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                dp_ctrl.op = OP_DIFF;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // even steps estimate a digit, odd steps fix it
                dp_ctrl.op = cnt_reg[0] ? OP_DIV_FIX : OP_DIV_EST;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROUND:
            begin
                dp_ctrl.op = OP_ROUND;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                dp_ctrl.op = OP_SCALE;
                state_next = ST_SELECT;
            end
            ST_SELECT:
            begin
                dp_ctrl.op = OP_SELECT;
                state_next = ST_WEIGH;
            end
            ST_WEIGH:
            begin
                dp_ctrl.op = OP_WEIGH;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold here until the output register can take the beat
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_mark_next  = 1'b0;
                    out_post_next  = 1'b0;
                    state_next     = ST_IDLE;
                    unique case (kind_reg)
                        KIND_RESET:
                        begin
                            dp_ctrl.op = OP_CLEAR;
                        end
                        KIND_CHECK:
                        begin
                            dp_ctrl.op    = OP_COMMIT;
                            out_mark_next = dp_stat.mark;
                            out_post_next = dp_stat.post;
                        end
                        default:
                        begin
                            dp_ctrl.op = OP_NONE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_mark   = out_mark_reg;
    assign m_post   = out_post_reg;

endmodule

>>> rtl/tdtc_dp.sv
module tdtc_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tdtc_pkg::dp_ctrl_t            dp_ctrl,
    output tdtc_pkg::dp_stat_t            dp_stat,
    input  tdtc_pkg::event_t              ev,
    input  logic [tdtc_pkg::WRAP_W-1:0]   fiducial_wrap,
    input  logic [tdtc_pkg::LGAP_W-1:0]   long_gap_ns
);
    import tdtc_pkg::*;

    // Captured event
    logic [ACQ_W-1:0]  acq_reg;
    logic [FID_W-1:0]  fid_reg;
    logic [SEC_W-1:0]  sec_reg;
    logic [NSEC_W-1:0] nsec_reg;

    // Working values
    logic [TIME_W-1:0]       clk_ns_reg;
    logic [FGAP_W-1:0]       fid_gap_reg;
    logic [TIME_W-1:0]       evr_gap_reg;
    logic [TIME_W-1:0]       acq_quo_reg;
    logic [PS_PER_NS_W-1:0]  acq_rem_reg;
    logic [DIG_W-1:0]        acq_est_reg;
    logic [TIME_W-1:0]       clk_quo_reg;
    logic [NS_PER_FID_W-1:0] clk_rem_reg;
    logic [DIG_W-1:0]        clk_est_reg;
    logic [QRND_W-1:0]       q_rnd_reg;
    logic [TIME_W-1:0]       clk_gap_reg;
    logic [TIME_W-1:0]       ref_reg;
    logic [TIME_W-1:0]       mis_reg;
    logic [WEIGH_W-1:0]      lhs_reg;
    logic [WEIGH_W-1:0]      rhs_reg;

    // Persistent state
    logic [ACQ_W-1:0]  last_acq_reg;
    logic [FID_W-1:0]  last_fid_reg;
    logic [TIME_W-1:0] last_clk_reg;
    logic              started_reg;
    logic              ooo_reg;

    logic [2*SEC_W-3:0]      sec_ns;
    logic [FGAP_W-1:0]       fid_gap_next;
    logic [ACQ_T_W-1:0]      acq_t;
    logic [ACQ_T_W+RCP_W-1:0] acq_est_prod;
    logic [ACQ_T_W-1:0]      acq_try;
    logic                    acq_fix;
    logic [CLK_T_W-1:0]      clk_t;
    logic [CLK_T_W+RCP_W-1:0] clk_est_prod;
    logic [CLK_T_W-1:0]      clk_try;
    logic                    clk_fix;
    logic                    round_up;
    logic [QRND_W+NS_PER_FID_W-1:0] clk_prod;
    logic [FGAP_W+NS_PER_FID_W-1:0] evr_prod;
    logic [TIME_W-1:0]       ref_sel;
    logic                    gt;

    assign sec_ns = (2*SEC_W-2)'(sec_reg) * (2*SEC_W-2)'(NS_PER_S);

    always_comb
    begin
        if (fid_reg > last_fid_reg)
        begin
            fid_gap_next = FGAP_W'(fid_reg) - FGAP_W'(last_fid_reg);
        end
        else
        begin
            // equal fiducials give a full wrap; a negative sum wraps at 2^32
            fid_gap_next = FGAP_W'(fid_reg) - FGAP_W'(last_fid_reg) + FGAP_W'(fiducial_wrap);
        end
    end

    // long division, one 16-bit digit per estimate/fix pair; the quotient
    // register holds the dividend and takes the digits in from the bottom
    assign acq_t        = {acq_rem_reg, acq_quo_reg[TIME_W-1 -: DIG_W]};
    assign acq_est_prod = (ACQ_T_W+RCP_W)'(acq_t) * (ACQ_T_W+RCP_W)'(ACQ_RCP);
    assign acq_try      = acq_t - ACQ_T_W'(acq_est_reg) * ACQ_T_W'(PS_PER_NS);
    assign acq_fix      = acq_try >= ACQ_T_W'(PS_PER_NS);

    assign clk_t        = {clk_rem_reg, clk_quo_reg[TIME_W-1 -: DIG_W]};
    assign clk_est_prod = (CLK_T_W+RCP_W)'(clk_t) * (CLK_T_W+RCP_W)'(CLK_RCP);
    assign clk_try      = clk_t - CLK_T_W'(clk_est_reg) * CLK_T_W'(NS_PER_FIDUCIAL);
    assign clk_fix      = clk_try >= CLK_T_W'(NS_PER_FIDUCIAL);

    assign round_up = {clk_rem_reg, 1'b0} >= (NS_PER_FID_W+1)'(NS_PER_FIDUCIAL);
    assign clk_prod = (QRND_W+NS_PER_FID_W)'(q_rnd_reg)
                    * (QRND_W+NS_PER_FID_W)'(NS_PER_FIDUCIAL);
    assign evr_prod = (FGAP_W+NS_PER_FID_W)'(fid_gap_reg)
                    * (FGAP_W+NS_PER_FID_W)'(NS_PER_FIDUCIAL);
    assign ref_sel  = (clk_gap_reg > TIME_W'(long_gap_ns)) ? clk_gap_reg : evr_gap_reg;

    assign gt           = lhs_reg > rhs_reg;
    assign dp_stat.post = started_reg && !ooo_reg && gt;
    assign dp_stat.mark = ooo_reg || dp_stat.post;

    always_ff @(posedge clk)
    begin
        unique case (dp_ctrl.op)
            OP_LOAD:
            begin
                acq_reg  <= ev.acq_time_ps;
                fid_reg  <= ev.fiducial;
                sec_reg  <= ev.clock_seconds;
                nsec_reg <= ev.clock_nanoseconds;
            end
            OP_PREP:
            begin
                clk_ns_reg  <= TIME_W'(sec_ns) + TIME_W'(nsec_reg);
                fid_gap_reg <= fid_gap_next;
                acq_quo_reg <= acq_reg - last_acq_reg;
                acq_rem_reg <= '0;
            end
            OP_DIFF:
            begin
                clk_quo_reg <= clk_ns_reg - last_clk_reg;
                clk_rem_reg <= '0;
                evr_gap_reg <= TIME_W'(evr_prod);
            end
            OP_DIV_EST:
            begin
                acq_est_reg <= acq_est_prod[ACQ_T_W +: DIG_W];
                clk_est_reg <= clk_est_prod[CLK_T_W +: DIG_W];
            end
            OP_DIV_FIX:
            begin
                // the estimate is at most one short: bump it and drop one divisor
                acq_rem_reg <= acq_fix ? PS_PER_NS_W'(acq_try - ACQ_T_W'(PS_PER_NS))
                                       : PS_PER_NS_W'(acq_try);
                acq_quo_reg <= {acq_quo_reg[TIME_W-DIG_W-1:0],
                                acq_est_reg + DIG_W'(acq_fix)};
                clk_rem_reg <= clk_fix
                    ? NS_PER_FID_W'(clk_try - CLK_T_W'(NS_PER_FIDUCIAL))
                    : NS_PER_FID_W'(clk_try);
                clk_quo_reg <= {clk_quo_reg[TIME_W-DIG_W-1:0],
                                clk_est_reg + DIG_W'(clk_fix)};
            end
            OP_ROUND:
            begin
                q_rnd_reg <= clk_quo_reg[QRND_W-1:0] + QRND_W'(round_up);
            end
            OP_SCALE:
            begin
                clk_gap_reg <= clk_prod[TIME_W-1:0];
            end
            OP_SELECT:
            begin
                ref_reg <= ref_sel;
                mis_reg <= (ref_sel >= acq_quo_reg) ? ref_sel - acq_quo_reg
                                                    : acq_quo_reg - ref_sel;
            end
            OP_WEIGH:
            begin
                lhs_reg <= WEIGH_W'(mis_reg) * WEIGH_W'(TOL_DEN);
                rhs_reg <= WEIGH_W'(ref_reg) * WEIGH_W'(TOL_NUM);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_acq_reg <= '0;
            last_fid_reg <= '0;
            last_clk_reg <= '0;
            started_reg  <= 1'b0;
            ooo_reg      <= 1'b0;
        end
        else if (dp_ctrl.op == OP_CLEAR)
        begin
            started_reg <= 1'b0;
            ooo_reg     <= 1'b0;
        end
        else if (dp_ctrl.op == OP_COMMIT)
        begin
            started_reg <= 1'b1;
            ooo_reg     <= dp_stat.mark;
            if (!dp_stat.mark)
            begin
                last_acq_reg <= acq_reg;
                last_fid_reg <= fid_reg;
                last_clk_reg <= clk_ns_reg;
            end
        end
    end

endmodule

>>> rtl/tdtc_checker.sv
module tdtc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [tdtc_pkg::M_DATA_W-1:0] m_tdata
);
    import tdtc_pkg::*;

    // a stalled result beat keeps its flags
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a readout clear always comes with the out-of-order mark
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[1] || m_tdata[0])
        else $error("readout clear without out-of-order mark");

    // one event at a time: ready drops right after an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an event is in work");

    // a new result only shows up at the end of an event's work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while idle");

endmodule

bind trigger_drop_timestamp_checker tdtc_checker u_checker (.*);

>>> bench/trigger_drop_timestamp_checker_tb.sv
`timescale 1ns / 1ps

module trigger_drop_timestamp_checker_tb;

    // Timing constants of the checker's arithmetic
    localparam logic [63:0]  FID_PERIOD_NS = 64'd2777777;
    localparam logic [63:0]  NS_PER_SEC    = 64'd1000000000;
    localparam logic [63:0]  PS_PER_NS     = 64'd1000;
    localparam logic [127:0] TOL_NUM       = 128'd13;
    localparam logic [127:0] TOL_DEN       = 128'd2000;

    // Register byte addresses
    localparam logic [tdtc_pkg::APB_AW-1:0] ADDR_FID_WRAP = 'h0;
    localparam logic [tdtc_pkg::APB_AW-1:0] ADDR_LONG_GAP = 'h8;

    // Reset values of the registers
    localparam logic [63:0] WRAP_DEFAULT = 64'd131040;
    localparam logic [63:0] GAP_DEFAULT  = 64'd300000000000;

    // Quiet cycles tolerated before the run is declared hung
    localparam int QUIET_LIMIT       = 3000;
    // Idle cycles at the end before the final check
    localparam int DRAIN_CYCLES      = 80;
    localparam int ITEMS_PER_SETTING = 117;

    // One input beat: cmd and damage flag travel on tuser, the stamps on tdata
    typedef struct packed {
        logic               damaged;
        logic               cmd;
        tdtc_pkg::event_t   stamp;
    } trig_t;

    // One output beat
    typedef struct packed {
        logic post;
        logic mark;
    } flags_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [tdtc_pkg::S_DATA_W-1:0]     s_tdata  = '0;
    logic [tdtc_pkg::S_USER_W-1:0]     s_tuser  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [tdtc_pkg::M_DATA_W-1:0]     m_tdata;
    logic                              psel     = 1'b0;
    logic                              penable  = 1'b0;
    logic                              pwrite   = 1'b0;
    logic [tdtc_pkg::APB_AW-1:0]       paddr    = '0;
    logic [tdtc_pkg::APB_DW-1:0]       pwdata   = '0;
    logic [tdtc_pkg::APB_DW-1:0]       prdata;
    logic                              pready;

    // Predictor copy of the registers and of the checker state
    logic [17:0] wrap_reg      = WRAP_DEFAULT[17:0];
    logic [39:0] long_gap_reg  = GAP_DEFAULT[39:0];
    logic [63:0] last_acq_ps   = '0;
    logic [16:0] last_fid      = '0;
    logic [63:0] last_clk_ns   = '0;
    logic        seen_first    = 1'b0;
    logic        drop_flag     = 1'b0;

    // Flags still owed by the block, oldest first
    flags_t pending_flags[$];

    int error_count   = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Event timeline for the well-formed random traffic
    logic [63:0] gen_acq;
    logic [63:0] gen_clk;
    int          gen_fid;

    trigger_drop_timestamp_checker i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Work out the flags of one event and advance the predicted state
    function automatic flags_t judge_event(input trig_t t);
        logic [31:0]  fid_gap;
        logic [63:0]  fid_span, acq_span, clk_ns, clk_span, quot, rem, ref_ns, miss;
        logic [127:0] miss_scaled, ref_scaled;
        flags_t       flags;
        flags = '0;
        // Run enable: drop both flags, keep the stored stamps
        if (t.cmd)
        begin
            drop_flag  = 1'b0;
            seen_first = 1'b0;
            return flags;
        end
        if (t.damaged)
            return flags;

        // Equal counts are a full turn of the fiducial counter
        if (t.stamp.fiducial > last_fid)
            fid_gap = 32'(t.stamp.fiducial) - 32'(last_fid);
        else
            fid_gap = 32'(t.stamp.fiducial) - 32'(last_fid) + 32'(wrap_reg);
        fid_span = 64'(fid_gap) * FID_PERIOD_NS;

        acq_span = (t.stamp.acq_time_ps - last_acq_ps) / PS_PER_NS;

        // Round the wall clock gap to whole fiducials, halves up
        clk_ns   = 64'(t.stamp.clock_seconds) * NS_PER_SEC + 64'(t.stamp.clock_nanoseconds);
        clk_span = clk_ns - last_clk_ns;
        quot     = clk_span / FID_PERIOD_NS;
        rem      = clk_span % FID_PERIOD_NS;
        if (rem * 64'd2 >= FID_PERIOD_NS)
            quot = quot + 64'd1;
        clk_span = quot * FID_PERIOD_NS;

        ref_ns = (clk_span > 64'(long_gap_reg)) ? clk_span : fid_span;
        miss   = (ref_ns >= acq_span) ? ref_ns - acq_span : acq_span - ref_ns;
        miss_scaled = 128'(miss) * TOL_DEN;
        ref_scaled  = 128'(ref_ns) * TOL_NUM;

        if (seen_first && !drop_flag && miss_scaled > ref_scaled)
        begin
            drop_flag  = 1'b1;
            flags.post = 1'b1;
        end
        if (drop_flag)
            flags.mark = 1'b1;
        else
        begin
            last_acq_ps = t.stamp.acq_time_ps;
            last_fid    = t.stamp.fiducial;
            last_clk_ns = clk_ns;
        end
        seen_first = 1'b1;
        return flags;
    endfunction

    // Largest digitizer error still inside the tolerance of a span
    function automatic logic [63:0] tolerance_ns(input logic [63:0] span);
        return span * 64'd13 / 64'd2000;
    endfunction

    function automatic tdtc_pkg::event_t stamp_at(input logic [63:0] acq,
                                                  input logic [16:0] fid,
                                                  input logic [63:0] clk_ns);
        tdtc_pkg::event_t s;
        s.acq_time_ps       = acq;
        s.fiducial          = fid;
        s.clock_seconds     = 32'(clk_ns / NS_PER_SEC);
        s.clock_nanoseconds = 30'(clk_ns % NS_PER_SEC);
        return s;
    endfunction

    function automatic trig_t make_trig(input logic cmd, input logic damaged,
                                        input tdtc_pkg::event_t stamp);
        trig_t t;
        t.cmd     = cmd;
        t.damaged = damaged;
        t.stamp   = stamp;
        return t;
    endfunction

    function automatic tdtc_pkg::event_t random_stamp();
        tdtc_pkg::event_t s;
        s.acq_time_ps       = {$urandom, $urandom};
        s.fiducial          = 17'($urandom_range(0, 131071));
        s.clock_seconds     = $urandom;
        s.clock_nanoseconds = 30'($urandom_range(0, 30'h3FFFFFFF));
        return s;
    endfunction

    // Counter modulus the random timeline follows; register values of 0 or above 131072 fall back
    function automatic int fid_modulus();
        if (wrap_reg >= 18'd1 && wrap_reg <= 18'd131072)
            return int'(wrap_reg);
        return 131072;
    endfunction

    // Drive one beat, hold it until accepted, then log its expected flags
    task automatic send_event(input trig_t t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, t.stamp};
        s_tuser  <= {t.damaged, t.cmd};
        do
            @(posedge clk);
        while (!s_tready);
        pending_flags.push_back(judge_event(t));
    endtask

    // Drop valid and wait until every owed beat has come back
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_flags.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup and access phase, then the bus is left idle before returning
    task automatic apb_transfer(input logic is_write,
                                input logic [tdtc_pkg::APB_AW-1:0] addr,
                                input logic [63:0] wdata, output logic [63:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rdata = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_register(input logic [tdtc_pkg::APB_AW-1:0] addr,
                                input logic [63:0] value);
        logic [63:0] unused;
        apb_transfer(1'b1, addr, value, unused);
        if (addr == ADDR_FID_WRAP)
            wrap_reg = value[17:0];
        else
            long_gap_reg = value[39:0];
    endtask

    task automatic check_register(input logic [tdtc_pkg::APB_AW-1:0] addr);
        logic [63:0] got, want;
        apb_transfer(1'b0, addr, '0, got);
        want = (addr == ADDR_FID_WRAP) ? 64'(wrap_reg) : 64'(long_gap_reg);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: register 0x%0h read, expected 0x%0h, got 0x%0h",
                     $time, addr, want, got);
        end
    endtask

    // Reset values, masking of wide writes, readback
    task automatic test_register_access();
        check_register(ADDR_FID_WRAP);
        check_register(ADDR_LONG_GAP);
        set_register(ADDR_FID_WRAP, 64'hFFFF_FFFF_FFFC_0005);
        set_register(ADDR_LONG_GAP, 64'hA5A5_A5A5_A5A5_A5A5);
        check_register(ADDR_FID_WRAP);
        check_register(ADDR_LONG_GAP);
        set_register(ADDR_FID_WRAP, WRAP_DEFAULT);
        set_register(ADDR_LONG_GAP, GAP_DEFAULT);
        check_register(ADDR_FID_WRAP);
        check_register(ADDR_LONG_GAP);
    endtask

    // Hand-built events around the tolerance edges, wraps and rounding
    task automatic test_directed_events();
        logic [63:0] acq, clk_ns, span;
        logic [16:0] fid;
        acq    = '0;
        fid    = '0;
        clk_ns = '0;
        // run enable and a damaged event, every bit set
        send_event(make_trig(1'b1, 1'b1, '1));
        send_event(make_trig(1'b0, 1'b1, '1));
        // first event after reset is stored, not checked
        send_event(make_trig(1'b0, 1'b0, stamp_at(acq, fid, clk_ns)));

        span = FID_PERIOD_NS;
        acq += span * PS_PER_NS; fid = 17'd1; clk_ns += span;
        send_event(make_trig(1'b0, 1'b0, stamp_at(acq, fid, clk_ns)));

        // digitizer late by exactly the tolerance, plus a sub-ns remainder
        span = 2 * FID_PERIOD_NS;
        acq += (span + tolerance_ns(span)) * PS_PER_NS + 64'd999; fid = 17'd3; clk_ns += span;
        send_event(make_trig(1'b0, 1'b0, stamp_at(acq, fid, clk_ns)));

        // digitizer early by exactly the tolerance
        span = FID_PERIOD_NS;
        acq += (span - tolerance_ns(span)) * PS_PER_NS; fid = 17'd4; clk_ns += span;
        send_event(make_trig(1'b0, 1'b0, stamp_at(acq, fid, clk_ns)));

        // run up to the top of the counter, then across the wrap
        span = 64'd131035 * FID_PERIOD_NS;
        acq += span * PS_PER_NS; fid = 17'd131039; clk_ns += span;
        send_event(make_trig(1'b0, 1'b0, stamp_at(acq, fid, clk_ns)));
        span = 2 * FID_PERIOD_NS;
        acq += span * PS_PER_NS; fid = 17'd1; clk_ns += span;
        send_event(make_trig(1'b0, 1'b0, stamp_at(acq, fid, clk_ns)));

        // same count again means a full turn
        span = 64'd131040 * FID_PERIOD_NS;
        acq += span * PS_PER_NS; clk_ns += span;
        send_event(make_trig(1'b0, 1'b0, stamp_at(acq, fid, clk_ns)));

        // long pause: the clock overrides a one-fiducial count
        span = 64'd144000 * FID_PERIOD_NS;
        acq += span * PS_PER_NS; fid = 17'd2; clk_ns += span;
        send_event(make_trig(1'b0, 1'b0, stamp_at(acq, fid, clk_ns)));

        // half a period on the clock rounds up; digitizer at the upper edge
        span = 64'd108011 * FID_PERIOD_NS;
        acq += (span + tolerance_ns(span)) * PS_PER_NS; fid = 17'd3;
        clk_ns += span - FID_PERIOD_NS + 64'd1388889;
        send_event(make_trig(1'b0, 1'b0, stamp_at(acq, fid, clk_ns)));

        // just under half rounds down; digitizer at the lower edge
        span = 64'd108010 * FID_PERIOD_NS;
        acq += (span - tolerance_ns(span)) * PS_PER_NS; fid = 17'd4;
        clk_ns += span + 64'd1388888;
        send_event(make_trig(1'b0, 1'b0, stamp_at(acq, fid, clk_ns)));

        // one ns past the edge: drop detected, stamps no longer stored
        span = FID_PERIOD_NS;
        send_event(make_trig(1'b0, 1'b0, stamp_at(acq + (span + tolerance_ns(span) + 1)
                                                  * PS_PER_NS, 17'd5, clk_ns + span)));
        // consistent event is still marked; damaged one is not
        span = 2 * FID_PERIOD_NS;
        send_event(make_trig(1'b0, 1'b0, stamp_at(acq + span * PS_PER_NS, 17'd6,
                                                  clk_ns + span)));
        span = 3 * FID_PERIOD_NS;
        send_event(make_trig(1'b0, 1'b1, stamp_at(acq + span * PS_PER_NS, 17'd7,
                                                  clk_ns + span)));

        // run enable, then field extremes and a wrap of every stamp
        send_event(make_trig(1'b1, 1'b0, '0));
        send_event(make_trig(1'b0, 1'b0, '1));
        send_event(make_trig(1'b0, 1'b0, '0));
        send_event(make_trig(1'b1, 1'b0, '0));
    endtask

    // Mostly a coherent timeline; some drops, long pauses, damage and noise
    task automatic send_random_event();
        trig_t       t;
        int          pick, k, extra, modulus;
        logic [63:0] step_ns;
        t       = '0;
        extra   = 0;
        pick    = $urandom_range(0, 99);
        modulus = fid_modulus();
        if (pick < 5)
        begin
            t.cmd     = 1'b1;
            t.damaged = 1'($urandom_range(0, 1));
            t.stamp   = random_stamp();
        end
        else if (pick < 10)
        begin
            t.damaged = 1'($urandom_range(0, 1));
            t.stamp   = random_stamp();
        end
        else
        begin
            k = $urandom_range(1, (modulus < 4) ? modulus : 4);
            step_ns = 64'(k) * FID_PERIOD_NS;
            // pause past the long-gap threshold
            if (pick < 14)
                step_ns = step_ns + 64'(long_gap_reg);
            // lost trigger: the counter moves one further than the stamps
            else if (pick < 19)
                extra = 1;
            t.damaged = (pick >= 19 && pick < 24);
            gen_clk = gen_clk + step_ns + 64'($urandom_range(0, 4000)) - 64'd2000;
            gen_acq = gen_acq + step_ns * PS_PER_NS
                      + 64'($urandom_range(0, 8000000)) - 64'd4000000;
            gen_fid = (gen_fid + k + extra) % modulus;
            t.stamp = stamp_at(gen_acq, 17'(gen_fid), gen_clk);
        end
        send_event(t);
    endtask

    // Three idling patterns, two register settings each
    task automatic test_random_events();
        logic [63:0] wrap_set[6];
        logic [63:0] gap_set[6];
        int          send_pct[3];
        int          recv_pct[3];
        int          idx;
        wrap_set = '{WRAP_DEFAULT, 64'd1, 64'd131072, 64'd0, '1, WRAP_DEFAULT};
        gap_set  = '{GAP_DEFAULT, 64'd0, '1, {$urandom, $urandom}, GAP_DEFAULT,
                     64'($urandom_range(0, 2000000000))};
        send_pct = '{17, 60, 0};
        recv_pct = '{60, 17, 0};
        gen_acq  = {$urandom, $urandom};
        gen_clk  = 64'($urandom_range(0, 32'hFFFE0000)) * NS_PER_SEC
                   + 64'($urandom_range(0, 999999999));
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = send_pct[ph];
            recv_idle_pct = recv_pct[ph];
            for (int s = 0; s < 2; s++)
            begin
                idx = ph * 2 + s;
                settle_block();
                set_register(ADDR_FID_WRAP, wrap_set[idx]);
                set_register(ADDR_LONG_GAP, gap_set[idx]);
                gen_fid = $urandom_range(0, fid_modulus() - 1);
                // resync: start each setting with a run enable
                send_event(make_trig(1'b1, 1'b0, random_stamp()));
                repeat (ITEMS_PER_SETTING) send_random_event();
            end
        end
    endtask

    // Check each returned beat against the oldest owed flags; randomize ready
    always @(posedge clk)
    begin
        flags_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_flags.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result beat, expected none, got 0x%0h",
                         $time, m_tdata);
            end
            else
            begin
                want = pending_flags.pop_front();
                if (m_tdata[0] !== want.mark)
                begin
                    error_count++;
                    $display("%0t: mark_out_of_order expected %0b, got %0b",
                             $time, want.mark, m_tdata[0]);
                end
                if (m_tdata[1] !== want.post)
                begin
                    error_count++;
                    $display("%0t: post_clear_readout expected %0b, got %0b",
                             $time, want.post, m_tdata[1]);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // End a hung run
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        send_idle_pct = 17;
        recv_idle_pct = 60;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_directed_events();
        test_random_events();

        settle_block();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_flags.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> trigger_drop_timestamp_checker.f
rtl/tdtc_pkg.sv
rtl/tdtc_ctrl.sv
rtl/tdtc_dp.sv
rtl/trigger_drop_timestamp_checker.sv
rtl/tdtc_checker.sv
bench/trigger_drop_timestamp_checker_tb.sv
